@@ design/slt_pkg.sv @@
// Shared types and constants for the sighting table with aging.
// Used by the channel interfaces, the table memory, the compare unit and the top level.
package slt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KEY_W      = 64;
    localparam int META_W     = 32;
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 3;
    localparam int DWELL_W    = 17;
    localparam int STALE_W    = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [DWELL_W-1:0] DWELL_RST = 17'd300;
    localparam logic [STALE_W-1:0] STALE_RST = 18'd1200;

    localparam logic [CFG_IDX_W-1:0] CFG_DWELL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE = 1'b1;

    localparam logic REQ_SIGHT   = 1'b0;
    localparam logic REQ_REFRESH = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_NEW     = 3'd0,
        EV_MERGE   = 3'd1,
        EV_FULL    = 3'd2,
        EV_PROMOTE = 3'd3,
        EV_DONE    = 3'd4
    } t_event;

    typedef struct packed {
        logic [KEY_W-1:0]          key_high;
        logic [KEY_W-1:0]          key_low;
        logic [META_W-1:0]         meta;
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         first;
        logic [TIME_W-1:0]         last;
    } t_entry;

    typedef struct packed {
        logic                      match;
        logic                      promote;
        logic                      stale;
        logic signed [LEVEL_W-1:0] avg;
    } t_verdict;

    typedef struct packed {
        t_event                    kind;
        logic [KEY_W-1:0]          key_high;
        logic [KEY_W-1:0]          key_low;
        logic [META_W-1:0]         meta;
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         first;
        logic [TIME_W-1:0]         last;
        logic                      last_item;
    } t_evt;

endpackage

@@ design/slt_if.sv @@
// Valid/ready channel interfaces: sighting/refresh requests, result events, register writes.
// Depends on slt_pkg for field widths.
interface slt_req_if;
    import slt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [TIME_W-1:0]         now_time;
    logic [KEY_W-1:0]          key_high;
    logic [KEY_W-1:0]          key_low;
    logic [META_W-1:0]         meta_word;
    logic signed [LEVEL_W-1:0] signal_level;

    modport source (output valid, req_type, now_time, key_high, key_low, meta_word,
                    signal_level, input ready);
    modport sink   (input valid, req_type, now_time, key_high, key_low, meta_word,
                    signal_level, output ready);
endinterface

interface slt_evt_if;
    import slt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         event_kind;
    logic [KEY_W-1:0]          out_key_high;
    logic [KEY_W-1:0]          out_key_low;
    logic [META_W-1:0]         out_meta;
    logic signed [LEVEL_W-1:0] out_level;
    logic [TIME_W-1:0]         first_seen;
    logic [TIME_W-1:0]         last_seen;
    logic                      last_item;

    modport source (output valid, event_kind, out_key_high, out_key_low, out_meta,
                    out_level, first_seen, last_seen, last_item, input ready);
    modport sink   (input valid, event_kind, out_key_high, out_key_low, out_meta,
                    out_level, first_seen, last_seen, last_item, output ready);
endinterface

interface slt_cfg_if;
    import slt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/slt_mem.sv @@
// Beacon table storage: one write port, one read port with registered read data.
// Depends on slt_pkg for the entry type.
module slt_mem #(
    parameter int DEPTH = slt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  slt_pkg::t_entry      i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output slt_pkg::t_entry      o_rdata
);
    import slt_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/slt_eval.sv @@
// Shared compare unit: key match, dwell and age checks, level averaging for one entry.
// Depends on slt_pkg for the entry and verdict types.
module slt_eval (
    input  slt_pkg::t_entry                     i_entry,
    input  logic [slt_pkg::KEY_W-1:0]           i_key_high,
    input  logic [slt_pkg::KEY_W-1:0]           i_key_low,
    input  logic [slt_pkg::META_W-1:0]          i_meta,
    input  logic signed [slt_pkg::LEVEL_W-1:0]  i_level,
    input  logic [slt_pkg::TIME_W-1:0]          i_now,
    input  logic [slt_pkg::DWELL_W-1:0]         i_dwell,
    input  logic [slt_pkg::STALE_W-1:0]         i_stale,
    output slt_pkg::t_verdict                   o_verdict
);
    import slt_pkg::*;

    logic [TIME_W-1:0]         dwell_time;
    logic [TIME_W-1:0]         age_time;
    logic signed [LEVEL_W:0]   level_sum;
    logic signed [LEVEL_W:0]   level_adj;

    always_comb begin
        dwell_time = i_entry.last - i_entry.first;
        age_time   = i_now - i_entry.last;
        level_sum  = {i_entry.level[LEVEL_W-1], i_entry.level} + {i_level[LEVEL_W-1], i_level};
        // bias negative sums by one so the halving truncates toward zero
        level_adj  = level_sum + {{LEVEL_W{1'b0}}, level_sum[LEVEL_W]};

        o_verdict.match   = (i_entry.key_high == i_key_high) && (i_entry.key_low == i_key_low)
                            && (i_entry.meta == i_meta);
        o_verdict.promote = dwell_time >= {{(TIME_W-DWELL_W){1'b0}}, i_dwell};
        o_verdict.stale   = age_time > {{(TIME_W-STALE_W){1'b0}}, i_stale};
        o_verdict.avg     = level_adj[LEVEL_W:1];
    end

endmodule

@@ design/sighting_table_with_aging.sv @@
// Sighting table with aging. Holds up to TABLE_DEPTH beacons in a table with one write port
// and one registered read port, and walks it under a small sequencer, one entry at a time
// through one compare unit; each table read has a read state and a compare state because
// the read data is registered. A sighting scans upward from entry zero to the first hit or
// the last entry; an empty table goes straight to the miss step. A refresh is a descending
// scan that emits promoted entries and marks survivors, then an ascending compaction pass,
// then the done beat; a full result register holds the sequencer at any beat it emits. The
// request channel is ready only when the sequencer is idle; register writes are always taken.
// Depends on slt_pkg, slt_if, slt_mem and slt_eval.
module sighting_table_with_aging #(
    parameter int TABLE_DEPTH = slt_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slt_req_if.sink    i_req,
    slt_evt_if.source  o_evt,
    slt_cfg_if.sink    i_cfg
);
    import slt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_MISS,
        S_RF_RD,
        S_RF_CMP,
        S_CP_RD,
        S_CP_WR,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [IDX_W-1:0]          r_wr, n_wr;
    logic [TABLE_DEPTH-1:0]    r_keep, n_keep;
    logic                      r_out_valid, n_out_valid;
    t_evt                      r_evt, n_evt;
    logic [DWELL_W-1:0]        r_dwell;
    logic [STALE_W-1:0]        r_stale;

    logic [KEY_W-1:0]          r_key_high, n_key_high;
    logic [KEY_W-1:0]          r_key_low, n_key_low;
    logic [META_W-1:0]         r_meta, n_meta;
    logic signed [LEVEL_W-1:0] r_level, n_level;
    logic [TIME_W-1:0]         r_now, n_now;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    t_entry                    mem_wdata;
    t_entry                    rd_entry;
    t_verdict                  verdict;
    logic                      can_emit;
    logic [IDX_W-1:0]          last_idx;

    slt_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    slt_eval u_eval (
        .i_entry    (rd_entry),
        .i_key_high (r_key_high),
        .i_key_low  (r_key_low),
        .i_meta     (r_meta),
        .i_level    (r_level),
        .i_now      (r_now),
        .i_dwell    (r_dwell),
        .i_stale    (r_stale),
        .o_verdict  (verdict)
    );

    assign can_emit  = !r_out_valid || o_evt.ready;
    assign last_idx  = IDX_W'(r_count - 1'b1);
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_evt.kind;
    assign o_evt.out_key_high = r_evt.key_high;
    assign o_evt.out_key_low  = r_evt.key_low;
    assign o_evt.out_meta     = r_evt.meta;
    assign o_evt.out_level    = r_evt.level;
    assign o_evt.first_seen   = r_evt.first;
    assign o_evt.last_seen    = r_evt.last;
    assign o_evt.last_item    = r_evt.last_item;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_keep      = r_keep;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_evt       = r_evt;
        n_key_high  = r_key_high;
        n_key_low   = r_key_low;
        n_meta      = r_meta;
        n_level     = r_level;
        n_now       = r_now;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = rd_entry;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key_high = i_req.key_high;
                    n_key_low  = i_req.key_low;
                    n_meta     = i_req.meta_word;
                    n_level    = i_req.signal_level;
                    n_now      = i_req.now_time;
                    if (i_req.req_type == REQ_SIGHT) begin
                        n_idx   = '0;
                        n_state = (r_count == '0) ? S_MISS : S_LK_RD;
                    end else begin
                        n_idx   = last_idx;
                        n_state = (r_count == '0) ? S_DONE : S_RF_RD;
                    end
                end
            end
            S_LK_RD: begin
                n_state = S_LK_CMP;
            end
            S_LK_CMP: begin
                if (verdict.match) begin
                    // hold the read address until the result register frees up
                    if (can_emit) begin
                        mem_we          = 1'b1;
                        mem_wdata.level = verdict.avg;
                        mem_wdata.last  = r_now;
                        n_out_valid     = 1'b1;
                        n_evt           = '0;
                        n_evt.kind      = EV_MERGE;
                        n_evt.level     = verdict.avg;
                        n_evt.last_item = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (r_idx == last_idx) begin
                    n_state = S_MISS;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LK_RD;
                end
            end
            S_MISS: begin
                if (can_emit) begin
                    n_out_valid     = 1'b1;
                    n_evt           = '0;
                    n_evt.last_item = 1'b1;
                    if (r_count == DEPTH_CNT) begin
                        n_evt.kind = EV_FULL;
                    end else begin
                        mem_we             = 1'b1;
                        mem_waddr          = IDX_W'(r_count);
                        mem_wdata.key_high = r_key_high;
                        mem_wdata.key_low  = r_key_low;
                        mem_wdata.meta     = r_meta;
                        mem_wdata.level    = r_level;
                        mem_wdata.first    = r_now;
                        mem_wdata.last     = r_now;
                        n_count            = r_count + 1'b1;
                        n_evt.kind         = EV_NEW;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RF_RD: begin
                n_state = S_RF_CMP;
            end
            S_RF_CMP: begin
                if (!verdict.promote || can_emit) begin
                    if (verdict.promote) begin
                        n_out_valid     = 1'b1;
                        n_evt.kind      = EV_PROMOTE;
                        n_evt.key_high  = rd_entry.key_high;
                        n_evt.key_low   = rd_entry.key_low;
                        n_evt.meta      = rd_entry.meta;
                        n_evt.level     = rd_entry.level;
                        n_evt.first     = rd_entry.first;
                        n_evt.last      = rd_entry.last;
                        n_evt.last_item = 1'b0;
                    end
                    n_keep[r_idx] = !verdict.promote && !verdict.stale;
                    if (r_idx == '0) begin
                        n_wr    = '0;
                        n_state = S_CP_RD;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RF_RD;
                    end
                end
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                // slide survivors down in their original order
                if (r_keep[r_idx]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr;
                    n_wr      = r_wr + 1'b1;
                end
                if (r_idx == last_idx) begin
                    n_count = CNT_W'(r_wr) + CNT_W'(r_keep[r_idx]);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    n_out_valid     = 1'b1;
                    n_evt           = '0;
                    n_evt.kind      = EV_DONE;
                    n_evt.last_item = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dwell     <= DWELL_RST;
            r_stale     <= STALE_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_DWELL: r_dwell <= i_cfg.data[DWELL_W-1:0];
                    CFG_STALE: r_stale <= i_cfg.data[STALE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_wr       <= n_wr;
        r_keep     <= n_keep;
        r_evt      <= n_evt;
        r_key_high <= n_key_high;
        r_key_low  <= n_key_low;
        r_meta     <= n_meta;
        r_level    <= n_level;
        r_now      <= n_now;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_WR) && mem_we |-> (r_wr <= r_idx))
        else $error("compaction write ahead of read pointer");

    a_promote_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_evt.kind == EV_PROMOTE) |-> !r_evt.last_item)
        else $error("promoted entry flagged as final beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while sequencer busy");

endmodule

@@ tb/sighting_table_with_aging_chk.sv @@
`timescale 1ns / 100ps
// Result checker for the sighting table: mirrors the table and registers on every accepted
// request and register write, then compares each result beat field by field.
// Depends on slt_pkg and the channel interfaces in slt_if.
module sighting_table_with_aging_chk #(
    parameter int TABLE_DEPTH = slt_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    slt_req_if   i_req,
    slt_evt_if   i_evt,
    slt_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);
    import slt_pkg::*;

    t_entry             rows [TABLE_DEPTH];
    int                 row_count;
    logic [DWELL_W-1:0] dwell_min;
    logic [STALE_W-1:0] stale_max;
    t_evt               expected_events [$];

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns  mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic void drop_row(int idx);
        for (int j = idx; j + 1 < row_count; j++)
            rows[j] = rows[j + 1];
        row_count--;
    endfunction

    function automatic void predict_sighting(logic [TIME_W-1:0] now,
                                             logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl,
                                             logic [META_W-1:0] meta,
                                             logic signed [LEVEL_W-1:0] lvl);
        t_evt ev;
        int   hit;
        int   sum;
        ev = '0;
        ev.last_item = 1'b1;
        hit = -1;
        // lowest matching entry wins
        for (int i = 0; i < row_count; i++)
            if (hit < 0 && rows[i].key_high == kh && rows[i].key_low == kl &&
                rows[i].meta == meta)
                hit = i;
        if (hit >= 0) begin
            // int division truncates toward zero
            sum = int'(rows[hit].level) + int'(lvl);
            rows[hit].level = LEVEL_W'(sum / 2);
            rows[hit].last = now;
            ev.kind = EV_MERGE;
            ev.level = rows[hit].level;
        end else if (row_count >= TABLE_DEPTH) begin
            ev.kind = EV_FULL;
        end else begin
            rows[row_count] = '{kh, kl, meta, lvl, now, now};
            row_count++;
            ev.kind = EV_NEW;
        end
        expected_events.push_back(ev);
    endfunction

    function automatic void predict_refresh(logic [TIME_W-1:0] now);
        t_evt              ev;
        logic [TIME_W-1:0] dwell_span;
        logic [TIME_W-1:0] idle_span;
        // walk down so removals never disturb entries still to visit
        for (int k = row_count - 1; k >= 0; k--) begin
            dwell_span = rows[k].last - rows[k].first;
            idle_span = now - rows[k].last;
            if (dwell_span >= TIME_W'(dwell_min)) begin
                ev = '0;
                ev.kind = EV_PROMOTE;
                ev.key_high = rows[k].key_high;
                ev.key_low = rows[k].key_low;
                ev.meta = rows[k].meta;
                ev.level = rows[k].level;
                ev.first = rows[k].first;
                ev.last = rows[k].last;
                expected_events.push_back(ev);
                drop_row(k);
            end else if (idle_span > TIME_W'(stale_max)) begin
                drop_row(k);
            end
        end
        ev = '0;
        ev.kind = EV_DONE;
        ev.last_item = 1'b1;
        expected_events.push_back(ev);
    endfunction

    task automatic check_beat();
        t_evt want;
        if (expected_events.size() == 0) begin
            report_mismatch("unexpected result beat, event_kind", i_evt.event_kind, '0);
            return;
        end
        want = expected_events.pop_front();
        o_checked++;
        if (i_evt.event_kind !== want.kind)
            report_mismatch("event_kind", i_evt.event_kind, want.kind);
        if (i_evt.out_key_high !== want.key_high)
            report_mismatch("out_key_high", i_evt.out_key_high, want.key_high);
        if (i_evt.out_key_low !== want.key_low)
            report_mismatch("out_key_low", i_evt.out_key_low, want.key_low);
        if (i_evt.out_meta !== want.meta)
            report_mismatch("out_meta", i_evt.out_meta, want.meta);
        if (i_evt.out_level !== want.level)
            report_mismatch("out_level", 64'(i_evt.out_level), 64'(want.level));
        if (i_evt.first_seen !== want.first)
            report_mismatch("first_seen", i_evt.first_seen, want.first);
        if (i_evt.last_seen !== want.last)
            report_mismatch("last_seen", i_evt.last_seen, want.last);
        if (i_evt.last_item !== want.last_item)
            report_mismatch("last_item", i_evt.last_item, want.last_item);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_count = 0;
            dwell_min = DWELL_RST;
            stale_max = STALE_RST;
            expected_events.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_DWELL)
                    dwell_min = i_cfg.data[DWELL_W-1:0];
                else if (i_cfg.index == CFG_STALE)
                    stale_max = i_cfg.data[STALE_W-1:0];
            end
            // predict first: a beat taken on this edge belongs to an older request
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_REFRESH)
                    predict_refresh(i_req.now_time);
                else
                    predict_sighting(i_req.now_time, i_req.key_high, i_req.key_low,
                                     i_req.meta_word, i_req.signal_level);
            end
            if (i_evt.valid && i_evt.ready)
                check_beat();
        end
        o_outstanding <= expected_events.size();
    end

endmodule

@@ tb/sighting_table_with_aging_tb.sv @@
`timescale 1ns / 100ps
// Top of the sighting table testbench: clock, reset, request and register stimulus,
// result-side stalls, watchdog and verdict. Depends on slt_pkg, slt_if, the block
// and sighting_table_with_aging_chk.
module sighting_table_with_aging_tb;
    import slt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int POOL        = 20;
    localparam int STALL_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    slt_req_if req_ch ();
    slt_evt_if evt_ch ();
    slt_cfg_if cfg_ch ();

    int fail_count;
    int outstanding;
    int checked;
    int quiet_cycles;
    int n_sight;
    int n_refresh;
    int n_writes;
    bit idle_bursts = 1'b1;

    logic [KEY_W-1:0]  pool_high [POOL];
    logic [KEY_W-1:0]  pool_low  [POOL];
    logic [META_W-1:0] pool_meta [POOL];

    always #6 i_clk = ~i_clk;

    sighting_table_with_aging #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_evt   (evt_ch),
        .i_cfg   (cfg_ch)
    );

    sighting_table_with_aging_chk #(.TABLE_DEPTH(DEPTH)) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_evt         (evt_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result side: ready in random runs, with stall bursts while enabled
    initial begin
        forever begin
            if (idle_bursts && $urandom_range(0, 3) == 0) begin
                evt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                evt_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // end the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("sighting_table_with_aging_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid stays high into the next request unless a gap is drawn
    task automatic send_req(logic kind, logic [TIME_W-1:0] t,
                            logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl,
                            logic [META_W-1:0] meta, logic signed [LEVEL_W-1:0] lvl);
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.now_time     <= t;
        req_ch.key_high     <= kh;
        req_ch.key_low      <= kl;
        req_ch.meta_word    <= meta;
        req_ch.signal_level <= lvl;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind == REQ_REFRESH)
            n_refresh++;
        else
            n_sight++;
    endtask

    // refresh with junk in the fields it ignores
    task automatic send_refresh(logic [TIME_W-1:0] t);
        send_req(REQ_REFRESH, t, rand64(), rand64(), $urandom, LEVEL_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        n_writes++;
    endtask

    // drop valid and wait until every predicted beat has come back
    task automatic settle(int extra);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // fresh keys; every odd slot is its neighbor with one bit flipped
    task automatic refill_pool();
        for (int i = 0; i < POOL; i++) begin
            if (i % 2 == 1) begin
                pool_high[i] = pool_high[i - 1];
                pool_low[i]  = pool_low[i - 1];
                pool_meta[i] = pool_meta[i - 1];
                case ($urandom_range(0, 2))
                    0: pool_high[i] = pool_high[i] ^ (64'd1 << $urandom_range(0, 63));
                    1: pool_low[i]  = pool_low[i] ^ (64'd1 << $urandom_range(0, 63));
                    default: pool_meta[i] = pool_meta[i] ^ (32'd1 << $urandom_range(0, 31));
                endcase
            end else begin
                pool_high[i] = rand64();
                pool_low[i]  = rand64();
                pool_meta[i] = $urandom;
            end
        end
    endtask

    initial begin
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  now_s;
        logic [DWELL_W-1:0] dwell_set;
        logic [STALE_W-1:0] stale_set;
        int                 roll;
        int                 pick;

        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_SIGHT;
        req_ch.now_time     <= '0;
        req_ch.key_high     <= '0;
        req_ch.key_low      <= '0;
        req_ch.meta_word    <= '0;
        req_ch.signal_level <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_DWELL;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under reset register values; times straddle the 32-bit wrap
        t0 = 32'hFFFF_FF80;
        send_refresh(t0);
        send_req(REQ_SIGHT, t0,      '0, '0, '0, 8'sh80);
        send_req(REQ_SIGHT, t0 + 10, '0, '0, '0, 8'sh81);
        send_req(REQ_SIGHT, t0 + 20, '1, '1, '1, 8'sh7F);
        send_req(REQ_SIGHT, t0 + 30, '1, '1, '1, 8'sh7F);
        // near-miss keys: each differs from the first entry in one bit
        send_req(REQ_SIGHT, t0 + 40, '0, 64'd1, '0, 8'shFF);
        send_req(REQ_SIGHT, t0 + 50, '0, 64'd1, '0, 8'sh00);
        send_req(REQ_SIGHT, t0 + 60, {1'b1, 63'd0}, '0, '0, 8'sh05);
        send_req(REQ_SIGHT, t0 + 70, '0, '0, 32'h8000_0000, 8'shFA);
        send_req(REQ_SIGHT, t0 + 400, '0, '0, '0, 8'sh64);
        send_refresh(t0 + 400);
        for (int i = 0; i < 12; i++)
            send_req(REQ_SIGHT, t0 + 410 + i, rand64(), rand64(), $urandom,
                     LEVEL_W'($urandom));
        send_req(REQ_SIGHT, t0 + 500, rand64(), rand64(), $urandom, LEVEL_W'($urandom));
        send_refresh(t0 + 5000);
        settle(8);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin dwell_set = '0;        stale_set = '0;        end
                1: begin dwell_set = '1;        stale_set = '1;        end
                2: begin dwell_set = 17'd86400; stale_set = 18'd172800; end
                3: begin dwell_set = 17'd1;     stale_set = 18'd1;     end
                default: begin
                    dwell_set = DWELL_W'($urandom_range(10, 200));
                    stale_set = STALE_W'($urandom_range(30, 600));
                end
            endcase
            write_reg(CFG_DWELL, CFG_DATA_W'(dwell_set));
            write_reg(CFG_STALE, CFG_DATA_W'(stale_set));
            idle_bursts <= (p < 5);
            refill_pool();
            now_s = (p == 1) ? 32'hFFFF_F000 : $urandom;
            repeat (52) begin
                case ($urandom_range(0, 19))
                    0:       now_s = now_s + $urandom_range(100000, 300000);
                    1, 2:    now_s = now_s + $urandom_range(200, 2000);
                    default: now_s = now_s + $urandom_range(0, 40);
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    send_refresh(now_s);
                end else if (roll < 17) begin
                    send_req(REQ_SIGHT, now_s, rand64(), rand64(), $urandom,
                             LEVEL_W'($urandom));
                end else begin
                    pick = $urandom_range(0, POOL - 1);
                    send_req(REQ_SIGHT, now_s, pool_high[pick], pool_low[pick],
                             pool_meta[pick], LEVEL_W'($urandom));
                end
            end
            settle(8);
        end

        settle(40);
        $display("run covered %0d sightings and %0d refresh passes over %0d register writes",
                 n_sight, n_refresh, n_writes);
        $display("%0d result beats compared against the predicted table", checked);
        if (fail_count == 0 && outstanding == 0)
            $display("sighting_table_with_aging_tb: clean");
        else
            $display("sighting_table_with_aging_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
design/slt_pkg.sv
design/slt_if.sv
design/slt_mem.sv
design/slt_eval.sv
design/sighting_table_with_aging.sv
tb/sighting_table_with_aging_chk.sv
tb/sighting_table_with_aging_tb.sv
